@@ hw/rtl/msi_pkg.sv @@
// ----------------------------------------------------------------------------
// msi_pkg
// Shared types, op codes and Q16.16 arithmetic helpers for the sigmoid MLP.
// ----------------------------------------------------------------------------
`default_nettype none

package msi_pkg;

  typedef enum logic [2:0] {
    OP_WRITE_PARAM = 3'd0,
    OP_INPUT       = 3'd1,
    OP_TARGET      = 3'd2,
    OP_INFER       = 3'd3,
    OP_TRAIN       = 3'd4
  } op_e;

  // One output neuron held in the cell chain.
  typedef struct packed {
    logic signed [31:0] net;
    logic signed [31:0] g;
  } cell_t;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [23:0] PERCENT_SCALE = 24'd100;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    if (v < SAT_MIN) return -32'sh8000_0000;
    return v[31:0];
  endfunction

  // Floor of a Q32.32 product down to Q16.16.
  function automatic logic signed [63:0] floor16(input logic signed [63:0] p);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

  // Piecewise sigmoid on |x|, mirrored for negative inputs.
  function automatic logic [16:0] sigm(input logic signed [31:0] x);
    logic [31:0] ax;
    logic [16:0] y;
    ax = x[31] ? (~x + 32'd1) : x;
    if (ax >= 32'd327680) y = ONE_Q16;
    else if (ax >= 32'd155648) y = 17'(ax >> 5) + 17'd55296;
    else if (ax >= 32'd65536) y = 17'(ax >> 3) + 17'd40960;
    else y = 17'(ax >> 2) + 17'd32768;
    return x[31] ? (ONE_Q16 - y) : y;
  endfunction

  function automatic logic signed [31:0] dsigm(input logic signed [31:0] x);
    logic [16:0] s;
    logic [33:0] pr;
    s = sigm(x);
    pr = 34'(s) * 34'(ONE_Q16 - s);
    return {14'd0, pr[33:16]};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/msi_ram.sv @@
// ----------------------------------------------------------------------------
// msi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output logic      [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/msi_mul.sv @@
// ----------------------------------------------------------------------------
// msi_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/msi_cell.sv @@
// ----------------------------------------------------------------------------
// msi_cell
// One output-neuron cell: holds net input and gradient, passes them on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module msi_cell (
  input  wire logic           clk_i,
  input  wire logic           shift_i,
  input  wire msi_pkg::cell_t cell_i,
  output msi_pkg::cell_t      cell_o
);

  msi_pkg::cell_t cell_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      cell_q <= cell_i;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

@@ hw/rtl/mlp_sigmoid_infer_and_train.sv @@
// ----------------------------------------------------------------------------
// mlp_sigmoid_infer_and_train
// Sigmoid MLP with one hidden layer: parameter load, inference and one
// backprop step, built around one shared multiplier and a ring of output cells.
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  command   op_i addr_i value_i                            start & !busy
//  result    out_index_o out_value_o best_class_o           out_valid_o, 1 cycle
//            best_percent_o last_o
//  config    cfg_wdata_i                                    cfg_we_i
//
//  Load beats (ops 0..2) never raise busy.
//  Infer streams the hidden layer, then the output layer, through the single
//  multiplier; results then leave back to back, one per output.
//  Train then runs the backprop update sequencing on all weights and biases.
//  Reset clears control, sets learn_rate to 3277; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_sigmoid_infer_and_train #(
  parameter int INPUTS  = 64,
  parameter int HIDDEN  = 128,
  parameter int OUTPUTS = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op_i,
  input  wire logic [13:0]        addr_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  output logic [2:0]              out_index_o,
  output logic [16:0]             out_value_o,
  output logic [2:0]              best_class_o,
  output logic [6:0]              best_percent_o,
  output logic                    last_o,
  input  wire logic               cfg_we_i,
  input  wire logic [16:0]        cfg_wdata_i
);

  localparam int NIH = INPUTS * HIDDEN;
  localparam int NHO = HIDDEN * OUTPUTS;
  localparam int IW  = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int HW  = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int OW  = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int CW0 = (IW > HW) ? IW : HW;
  localparam int CW  = (CW0 > OW) ? CW0 : OW;
  localparam int WIH_AW = (NIH > 1) ? $clog2(NIH) : 1;
  localparam int WHO_AW = (NHO > 1) ? $clog2(NHO) : 1;
  localparam logic [31:0] B1 = 32'(NIH);
  localparam logic [31:0] B2 = 32'(NIH + NHO);
  localparam logic [31:0] B3 = 32'(NIH + NHO + HIDDEN);
  localparam logic [31:0] B4 = 32'(NIH + NHO + HIDDEN + OUTPUTS);

  typedef enum logic [4:0] {
    S_IDLE, S_HID, S_OUT, S_EMIT,
    S_GRD, S_GM1, S_GW,
    S_ORD, S_OM1, S_OW,
    S_HRD, S_HGET,
    S_TRD, S_TM1, S_TM2, S_TM3, S_TM4, S_TM5,
    S_JRD, S_JM1, S_JM2, S_JM3,
    S_BRD, S_BM1, S_BW
  } state_e;

  state_e state_q;
  logic [CW-1:0] oc_q, ic_q;
  logic [OW-1:0] kc_q, best_k_q;
  logic [16:0] best_v_q, lr_q;
  logic iss_q, v1_q, f1_q, l1_q, v2_q, l2_q, train_q;

  logic signed [63:0] acc_q;
  logic signed [31:0] w_q, wnew_q, dh_q, he_q, dsig_q;
  logic [16:0] hact_q;

  // ---- memories ----
  logic              wih_we, who_we, bh_we, bo_we, x_we, t_we, hn_we;
  logic [WIH_AW-1:0] wih_wa, wih_ra;
  logic [WHO_AW-1:0] who_wa, who_ra;
  logic [HW-1:0]     bh_wa, bh_ra, hn_wa, hn_ra;
  logic [OW-1:0]     bo_wa, bo_ra, t_wa, t_ra;
  logic [IW-1:0]     x_wa, x_ra;
  logic signed [31:0] wih_wd, who_wd, bh_wd, bo_wd, hn_wd;
  logic signed [31:0] wih_rd, who_rd, bh_rd, bo_rd, x_rd, t_rd, hn_rd;

  msi_ram #(.WIDTH(32), .DEPTH(NIH)) u_wih (
    .clk_i, .we_i(wih_we), .waddr_i(wih_wa), .wdata_i(wih_wd),
    .raddr_i(wih_ra), .rdata_o(wih_rd));
  msi_ram #(.WIDTH(32), .DEPTH(NHO)) u_who (
    .clk_i, .we_i(who_we), .waddr_i(who_wa), .wdata_i(who_wd),
    .raddr_i(who_ra), .rdata_o(who_rd));
  msi_ram #(.WIDTH(32), .DEPTH(HIDDEN)) u_bh (
    .clk_i, .we_i(bh_we), .waddr_i(bh_wa), .wdata_i(bh_wd),
    .raddr_i(bh_ra), .rdata_o(bh_rd));
  msi_ram #(.WIDTH(32), .DEPTH(OUTPUTS)) u_bo (
    .clk_i, .we_i(bo_we), .waddr_i(bo_wa), .wdata_i(bo_wd),
    .raddr_i(bo_ra), .rdata_o(bo_rd));
  msi_ram #(.WIDTH(32), .DEPTH(INPUTS)) u_x (
    .clk_i, .we_i(x_we), .waddr_i(x_wa), .wdata_i(value_i),
    .raddr_i(x_ra), .rdata_o(x_rd));
  msi_ram #(.WIDTH(32), .DEPTH(OUTPUTS)) u_t (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(value_i),
    .raddr_i(t_ra), .rdata_o(t_rd));
  msi_ram #(.WIDTH(32), .DEPTH(HIDDEN)) u_hn (
    .clk_i, .we_i(hn_we), .waddr_i(hn_wa), .wdata_i(hn_wd),
    .raddr_i(hn_ra), .rdata_o(hn_rd));

  // ---- multiplier ----
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  msi_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // ---- output cell ring ----
  msi_pkg::cell_t chain_in  [OUTPUTS];
  msi_pkg::cell_t chain_out [OUTPUTS];
  msi_pkg::cell_t head_in, tail;
  logic shift;

  for (genvar n = 0; n < OUTPUTS; n++) begin : g_cell
    if (n == 0) begin : g_head
      assign chain_in[n] = head_in;
    end else begin : g_link
      assign chain_in[n] = chain_out[n-1];
    end
    msi_cell u_cell (.clk_i, .shift_i(shift), .cell_i(chain_in[n]), .cell_o(chain_out[n]));
  end

  assign tail = chain_out[OUTPUTS-1];

  // ---- decode ----
  logic        ld;
  logic [31:0] a32, off_ho, off_bh, off_bo, wih_ra32, who_fa32, who_ta32;
  logic        ic_last_i, ic_last_h, oc_last_h, oc_last_o, kc_last, inner_last, fin;
  logic signed [63:0] sum_full, train_sum;
  logic signed [31:0] net_fin, qp, err;
  logic [16:0] act_fin, tail_act;
  logic [23:0] pct_full;

  assign busy   = (state_q != S_IDLE);
  assign ld     = start && !busy;
  assign a32    = 32'(addr_i);
  assign off_ho = a32 - B1;
  assign off_bh = a32 - B2;
  assign off_bo = a32 - B3;

  assign ic_last_i  = (ic_q == CW'(INPUTS - 1));
  assign ic_last_h  = (ic_q == CW'(HIDDEN - 1));
  assign oc_last_h  = (oc_q == CW'(HIDDEN - 1));
  assign oc_last_o  = (oc_q == CW'(OUTPUTS - 1));
  assign kc_last    = (kc_q == OW'(OUTPUTS - 1));
  assign inner_last = (state_q == S_HID) ? ic_last_i : ic_last_h;
  assign fin        = v2_q && l2_q;

  assign wih_ra32 = 32'(ic_q) * 32'(HIDDEN) + 32'(oc_q);
  assign who_fa32 = 32'(ic_q) * 32'(OUTPUTS) + 32'(oc_q);
  assign who_ta32 = 32'(oc_q) * 32'(OUTPUTS) + 32'(kc_q);

  assign qp        = msi_pkg::qsat(prod);
  assign sum_full  = acc_q + msi_pkg::floor16(prod);
  assign net_fin   = msi_pkg::sat32(sum_full);
  assign act_fin   = msi_pkg::sigm(net_fin);
  assign tail_act  = msi_pkg::sigm(tail.net);
  assign err       = msi_pkg::sat32(64'(t_rd) - $signed({47'd0, tail_act}));
  assign train_sum = acc_q + 64'(qp);
  assign pct_full  = 24'(best_v_q) * msi_pkg::PERCENT_SCALE;

  // Read addresses
  assign wih_ra = wih_ra32[WIH_AW-1:0];
  assign x_ra   = ic_q[IW-1:0];
  assign bh_ra  = oc_q[HW-1:0];
  assign who_ra = (state_q == S_OUT) ? who_fa32[WHO_AW-1:0] : who_ta32[WHO_AW-1:0];
  assign hn_ra  = (state_q == S_OUT) ? ic_q[HW-1:0] : oc_q[HW-1:0];
  assign bo_ra  = (state_q == S_OUT) ? oc_q[OW-1:0] : kc_q;
  assign t_ra   = kc_q;

  // Write ports: loads when idle, updates while busy
  always_comb begin
    wih_we = ld && (op_i == msi_pkg::OP_WRITE_PARAM) && (a32 < B1);
    who_we = ld && (op_i == msi_pkg::OP_WRITE_PARAM) && (a32 >= B1) && (a32 < B2);
    bh_we  = ld && (op_i == msi_pkg::OP_WRITE_PARAM) && (a32 >= B2) && (a32 < B3);
    bo_we  = ld && (op_i == msi_pkg::OP_WRITE_PARAM) && (a32 >= B3) && (a32 < B4);
    x_we   = ld && (op_i == msi_pkg::OP_INPUT) && (a32 < 32'(INPUTS));
    t_we   = ld && (op_i == msi_pkg::OP_TARGET) && (a32 < 32'(OUTPUTS));
    wih_wa = a32[WIH_AW-1:0];
    who_wa = off_ho[WHO_AW-1:0];
    bh_wa  = off_bh[HW-1:0];
    bo_wa  = off_bo[OW-1:0];
    x_wa   = a32[IW-1:0];
    t_wa   = a32[OW-1:0];
    wih_wd = value_i;
    who_wd = value_i;
    bh_wd  = value_i;
    bo_wd  = value_i;
    hn_we  = (state_q == S_HID) && fin;
    hn_wa  = oc_q[HW-1:0];
    hn_wd  = net_fin;
    if (busy) begin
      wih_we = (state_q == S_JM3);
      wih_wa = wih_ra32[WIH_AW-1:0];
      wih_wd = msi_pkg::sat32(64'(w_q) + 64'(qp));
      who_we = (state_q == S_TM3);
      who_wa = who_ta32[WHO_AW-1:0];
      who_wd = msi_pkg::sat32(64'(w_q) + 64'(qp));
      bh_we  = (state_q == S_BW);
      bh_wa  = oc_q[HW-1:0];
      bh_wd  = msi_pkg::sat32(64'(w_q) + 64'(qp));
      bo_we  = (state_q == S_OW);
      bo_wa  = kc_q;
      bo_wd  = msi_pkg::sat32(64'(w_q) + 64'(qp));
    end
  end

  // Multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_HID: begin mul_a = x_rd; mul_b = wih_rd; end
      S_OUT: begin mul_a = $signed({15'd0, msi_pkg::sigm(hn_rd)}); mul_b = who_rd; end
      S_GM1: begin mul_a = dsig_q; mul_b = err; end
      S_OM1: begin mul_a = tail.g; mul_b = $signed({15'd0, lr_q}); end
      S_TM1: begin mul_a = tail.g; mul_b = $signed({15'd0, hact_q}); end
      S_TM2: begin mul_a = qp; mul_b = $signed({15'd0, lr_q}); end
      S_TM3: begin mul_a = dh_q; mul_b = tail.g; end
      S_TM4: begin mul_a = qp; mul_b = wnew_q; end
      S_JM1: begin mul_a = he_q; mul_b = x_rd; end
      S_JM2: begin mul_a = qp; mul_b = $signed({15'd0, lr_q}); end
      S_BM1: begin mul_a = he_q; mul_b = $signed({15'd0, lr_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Ring shift and head input
  always_comb begin
    shift   = (state_q == S_EMIT) || (state_q == S_GW) || (state_q == S_OW) ||
              (state_q == S_TM5) || ((state_q == S_OUT) && fin);
    head_in = tail;
    if (state_q == S_OUT) begin
      head_in.net = net_fin;
      head_in.g   = '0;
    end else if (state_q == S_GW) begin
      head_in.g = qp;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_HID, S_OUT: begin
        if (v1_q && f1_q) begin
          acc_q <= (state_q == S_HID) ? 64'(bh_rd) : 64'(bo_rd);
        end else if (v2_q && !l2_q) begin
          acc_q <= sum_full;
        end
      end
      S_GRD:  dsig_q <= msi_pkg::dsigm(tail.net);
      S_OM1:  w_q <= bo_rd;
      S_HGET: begin
        dh_q   <= msi_pkg::dsigm(hn_rd);
        hact_q <= msi_pkg::sigm(hn_rd);
        acc_q  <= '0;
      end
      S_TM1:  w_q <= who_rd;
      S_TM3:  wnew_q <= who_wd;
      S_TM5: begin
        acc_q <= train_sum;
        if (kc_last) he_q <= msi_pkg::sat32(train_sum);
      end
      S_JM1:  w_q <= wih_rd;
      S_BM1:  w_q <= bh_rd;
      default: ;
    endcase
  end

  // Control, sequencing and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      oc_q           <= '0;
      ic_q           <= '0;
      kc_q           <= '0;
      iss_q          <= 1'b0;
      v1_q           <= 1'b0;
      f1_q           <= 1'b0;
      l1_q           <= 1'b0;
      v2_q           <= 1'b0;
      l2_q           <= 1'b0;
      train_q        <= 1'b0;
      best_v_q       <= '0;
      best_k_q       <= '0;
      lr_q           <= 17'd3277;
      out_valid_o    <= 1'b0;
      out_index_o    <= '0;
      out_value_o    <= '0;
      best_class_o   <= '0;
      best_percent_o <= '0;
      last_o         <= 1'b0;
    end else begin
      if (cfg_we_i) lr_q <= cfg_wdata_i;
      out_valid_o <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start && ((op_i == msi_pkg::OP_INFER) || (op_i == msi_pkg::OP_TRAIN))) begin
            state_q  <= S_HID;
            train_q  <= (op_i == msi_pkg::OP_TRAIN);
            oc_q     <= '0;
            ic_q     <= '0;
            iss_q    <= 1'b1;
            best_v_q <= '0;
            best_k_q <= '0;
          end
        end
        S_HID, S_OUT: begin
          // stream one product per cycle, drain, then close the neuron
          if (iss_q) begin
            if (inner_last) iss_q <= 1'b0;
            else ic_q <= ic_q + 1'b1;
          end
          v1_q <= iss_q;
          f1_q <= iss_q && (ic_q == '0);
          l1_q <= iss_q && inner_last;
          v2_q <= v1_q;
          l2_q <= v1_q && l1_q;
          if (fin) begin
            v2_q <= 1'b0;
            ic_q <= '0;
            if (state_q == S_HID) begin
              iss_q <= 1'b1;
              if (oc_last_h) begin
                state_q <= S_OUT;
                oc_q    <= '0;
              end else begin
                oc_q <= oc_q + 1'b1;
              end
            end else begin
              if (act_fin > best_v_q) begin
                best_v_q <= act_fin;
                best_k_q <= oc_q[OW-1:0];
              end
              if (oc_last_o) begin
                state_q <= S_EMIT;
                kc_q    <= '0;
              end else begin
                oc_q  <= oc_q + 1'b1;
                iss_q <= 1'b1;
              end
            end
          end
        end
        S_EMIT: begin
          out_valid_o    <= 1'b1;
          out_index_o    <= 3'(kc_q);
          out_value_o    <= tail_act;
          best_class_o   <= 3'(best_k_q);
          best_percent_o <= pct_full[22:16];
          last_o         <= kc_last;
          if (kc_last) begin
            kc_q    <= '0;
            state_q <= train_q ? S_GRD : S_IDLE;
          end else begin
            kc_q <= kc_q + 1'b1;
          end
        end
        S_GRD: state_q <= S_GM1;
        S_GM1: state_q <= S_GW;
        S_GW: begin
          if (kc_last) begin
            kc_q    <= '0;
            state_q <= S_ORD;
          end else begin
            kc_q    <= kc_q + 1'b1;
            state_q <= S_GRD;
          end
        end
        S_ORD: state_q <= S_OM1;
        S_OM1: state_q <= S_OW;
        S_OW: begin
          if (kc_last) begin
            kc_q    <= '0;
            oc_q    <= '0;
            state_q <= S_HRD;
          end else begin
            kc_q    <= kc_q + 1'b1;
            state_q <= S_ORD;
          end
        end
        S_HRD: state_q <= S_HGET;
        S_HGET: begin
          kc_q    <= '0;
          state_q <= S_TRD;
        end
        S_TRD: state_q <= S_TM1;
        S_TM1: state_q <= S_TM2;
        S_TM2: state_q <= S_TM3;
        S_TM3: state_q <= S_TM4;
        S_TM4: state_q <= S_TM5;
        S_TM5: begin
          if (kc_last) begin
            kc_q    <= '0;
            ic_q    <= '0;
            state_q <= S_JRD;
          end else begin
            kc_q    <= kc_q + 1'b1;
            state_q <= S_TRD;
          end
        end
        S_JRD: state_q <= S_JM1;
        S_JM1: state_q <= S_JM2;
        S_JM2: state_q <= S_JM3;
        S_JM3: begin
          if (ic_last_i) begin
            state_q <= S_BRD;
          end else begin
            ic_q    <= ic_q + 1'b1;
            state_q <= S_JRD;
          end
        end
        S_BRD: state_q <= S_BM1;
        S_BM1: state_q <= S_BW;
        S_BW: begin
          if (oc_last_h) begin
            state_q <= S_IDLE;
          end else begin
            oc_q    <= oc_q + 1'b1;
            state_q <= S_HRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
